// ===== rtl/stack_machine_executor_assert.svh =====
// Assertion helpers for the stack machine executor.
`ifndef STACK_MACHINE_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SME_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define SME_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// ===== rtl/sme_pkg.sv =====
package sme_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_PALL    = 3'd1,
    CMD_PINT    = 3'd2,
    CMD_POP     = 3'd3,
    CMD_SWAP    = 3'd4,
    CMD_ADD     = 3'd5,
    CMD_NOP     = 3'd6,
    CMD_INVALID = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_PINT_EMPTY = 3'd1,
    ERR_POP_EMPTY  = 3'd2,
    ERR_SWAP_SHORT = 3'd3,
    ERR_ADD_SHORT  = 3'd4,
    ERR_OVERFLOW   = 3'd5,
    ERR_INVALID    = 3'd6
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWAP2,
    ST_WALK
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH,
    OP_POP,
    OP_SWAP_HI,
    OP_SWAP_LO,
    OP_ADD,
    OP_PALL_FIRST,
    OP_PALL_NEXT
  } dp_op_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] operand;
  } req_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [2:0]         error_code;
    logic               last;
  } res_t;

  typedef struct packed {
    dp_op_t op;
    logic   emit;
    kind_t  kind;
    err_t   err;
    logic   last;
    logic   use_value;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic single;
    logic short_stack;
    logic full;
    logic idx_zero;
  } dp_status_t;

endpackage

// ===== rtl/sme_ctrl.sv =====
module sme_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          cmd_in,
  input  sme_pkg::dp_status_t status,
  output logic                busy,
  output sme_pkg::dp_cmd_t    dp_cmd
);
  import sme_pkg::*;

  state_t state, state_next;
  cmd_t   cmd_reg, cmd_reg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cmd_reg <= CMD_NOP;
    end else begin
      state   <= state_next;
      cmd_reg <= cmd_reg_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd_reg_next = cmd_reg;
    busy         = 1'b1;
    dp_cmd       = '{op: OP_NONE, emit: 1'b0, kind: KIND_ACK, err: ERR_NONE,
                     last: 1'b1, use_value: 1'b0};
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          dp_cmd.op    = OP_LOAD;
          cmd_reg_next = cmd_t'(cmd_in);
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        dp_cmd.emit = 1'b1;
        state_next  = ST_IDLE;
        unique case (cmd_reg)
          CMD_PUSH: begin
            if (status.full) begin
              dp_cmd.kind = KIND_ERROR;
              dp_cmd.err  = ERR_OVERFLOW;
            end else begin
              dp_cmd.op = OP_PUSH;
            end
          end
          CMD_PALL: begin
            if (!status.empty) begin
              dp_cmd.kind      = KIND_VALUE;
              dp_cmd.use_value = 1'b1;
              dp_cmd.last      = status.single;
              if (!status.single) begin
                dp_cmd.op  = OP_PALL_FIRST;
                state_next = ST_WALK;
              end
            end
          end
          CMD_PINT: begin
            if (status.empty) begin
              dp_cmd.kind = KIND_ERROR;
              dp_cmd.err  = ERR_PINT_EMPTY;
            end else begin
              dp_cmd.kind      = KIND_VALUE;
              dp_cmd.use_value = 1'b1;
            end
          end
          CMD_POP: begin
            if (status.empty) begin
              dp_cmd.kind = KIND_ERROR;
              dp_cmd.err  = ERR_POP_EMPTY;
            end else begin
              dp_cmd.op = OP_POP;
            end
          end
          CMD_SWAP: begin
            if (status.short_stack) begin
              dp_cmd.kind = KIND_ERROR;
              dp_cmd.err  = ERR_SWAP_SHORT;
            end else begin
              // one write port: lower entry goes in the next cycle
              dp_cmd.op  = OP_SWAP_HI;
              state_next = ST_SWAP2;
            end
          end
          CMD_ADD: begin
            if (status.short_stack) begin
              dp_cmd.kind = KIND_ERROR;
              dp_cmd.err  = ERR_ADD_SHORT;
            end else begin
              dp_cmd.op = OP_ADD;
            end
          end
          CMD_NOP: begin
          end
          CMD_INVALID: begin
            dp_cmd.kind = KIND_ERROR;
            dp_cmd.err  = ERR_INVALID;
          end
          default: begin
            dp_cmd.kind = KIND_ERROR;
            dp_cmd.err  = ERR_INVALID;
          end
        endcase
      end
      ST_SWAP2: begin
        dp_cmd.op  = OP_SWAP_LO;
        state_next = ST_IDLE;
      end
      ST_WALK: begin
        dp_cmd.op        = OP_PALL_NEXT;
        dp_cmd.emit      = 1'b1;
        dp_cmd.kind      = KIND_VALUE;
        dp_cmd.use_value = 1'b1;
        dp_cmd.last      = status.idx_zero;
        if (status.idx_zero) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sme_datapath.sv =====
module sme_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [31:0]  operand_in,
  input  sme_pkg::dp_cmd_t    dp_cmd,
  output sme_pkg::dp_status_t status,
  output logic                result_strobe,
  output sme_pkg::res_t       result
);
  import sme_pkg::*;

  logic [31:0]       mem [DEPTH];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [ADDR_W-1:0] idx;
  logic [31:0]       opnd;
  logic [31:0]       rd0;
  logic [31:0]       rd1;

  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [ADDR_W-1:0] top_addr;
  logic [ADDR_W-1:0] sec_addr;
  logic [ADDR_W-1:0] idx_m1;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic              wr_en;
  logic [ADDR_W-1:0] ra0;
  logic              rd0_en;
  logic              rd1_en;

  assign cnt_m1   = count - CNT_W'(1);
  assign cnt_m2   = count - CNT_W'(2);
  assign top_addr = cnt_m1[ADDR_W-1:0];
  assign sec_addr = cnt_m2[ADDR_W-1:0];
  assign idx_m1   = idx - ADDR_W'(1);

  assign status.empty       = (count == '0);
  assign status.single      = (count == CNT_W'(1));
  assign status.short_stack = (count < CNT_W'(2));
  assign status.full        = (count >= CNT_W'(DEPTH));
  assign status.idx_zero    = (idx == '0);

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = top_addr;
    wr_data    = rd1;
    ra0        = top_addr;
    rd0_en     = 1'b0;
    rd1_en     = 1'b0;
    count_next = count;
    unique case (dp_cmd.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        rd0_en = 1'b1;
        rd1_en = 1'b1;
      end
      OP_PUSH: begin
        wr_en      = 1'b1;
        wr_addr    = count[ADDR_W-1:0];
        wr_data    = opnd;
        count_next = count + CNT_W'(1);
      end
      OP_POP: begin
        count_next = cnt_m1;
      end
      OP_SWAP_HI: begin
        wr_en   = 1'b1;
        wr_addr = top_addr;
        wr_data = rd1;
      end
      OP_SWAP_LO: begin
        wr_en   = 1'b1;
        wr_addr = sec_addr;
        wr_data = rd0;
      end
      OP_ADD: begin
        wr_en      = 1'b1;
        wr_addr    = sec_addr;
        wr_data    = rd0 + rd1;
        count_next = cnt_m1;
      end
      OP_PALL_FIRST: begin
        ra0    = sec_addr;
        rd0_en = 1'b1;
      end
      OP_PALL_NEXT: begin
        ra0    = idx_m1;
        rd0_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd0_en) begin
      rd0 <= mem[ra0];
    end
    if (rd1_en) begin
      rd1 <= mem[sec_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.op == OP_LOAD) begin
      opnd <= operand_in;
    end
    if (dp_cmd.op == OP_PALL_FIRST) begin
      idx <= sec_addr;
    end else if (dp_cmd.op == OP_PALL_NEXT) begin
      idx <= idx_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      result_strobe <= 1'b0;
    end else begin
      count         <= count_next;
      result_strobe <= dp_cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit) begin
      result.kind       <= dp_cmd.kind;
      result.value      <= dp_cmd.use_value ? rd0 : 32'd0;
      result.error_code <= dp_cmd.err;
      result.last       <= dp_cmd.last;
    end
  end

endmodule

// ===== rtl/stack_machine_executor.sv =====
// Stack machine executor: one command per accepted request on a bounded stack.
// The result strobe is registered from the EXEC state's emit; busy stays high after accept
// through EXEC (and SWAP2 for swap, WALK for pall), so a new command waits for the last.
// pall on n elements strobes n results on consecutive cycles, one stack read per cycle.
// Rate is set by the registered read of the single-write-port stack memory.
// Synchronous reset empties the stack; results cannot be stalled by the receiver.
`include "stack_machine_executor_assert.svh"

module stack_machine_executor (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sme_pkg::req_t request,
  output logic          result_strobe,
  output sme_pkg::res_t result
);
  import sme_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t status;

  sme_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd_in (request.cmd),
    .status (status),
    .busy   (busy),
    .dp_cmd (dp_cmd)
  );

  sme_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .operand_in    (request.operand),
    .dp_cmd        (dp_cmd),
    .status        (status),
    .result_strobe (result_strobe),
    .result        (result)
  );

  `SME_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `SME_ASSERT_NXT(a_no_early_result, clk, rst, start && !busy, !result_strobe)
  `SME_ASSERT_IMP(a_error_is_final, clk, rst,
    result_strobe && (result.kind == KIND_ERROR),
    result.last && (result.error_code != ERR_NONE) && (result.value == 32'd0))
  `SME_ASSERT_IMP(a_no_push_when_full, clk, rst, dp_cmd.op == OP_PUSH, !status.full)

endmodule

// ===== bench/stack_machine_executor_checker.sv =====
module stack_machine_executor_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  sme_pkg::req_t  request,
  input  logic           result_strobe,
  input  sme_pkg::res_t  result,
  output int             fail_count,
  output int             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import sme_pkg::*;

  logic signed [31:0] stack_mem [DEPTH];
  int                 stack_depth;
  res_t               expected_q [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    stack_depth = 0;
  end

  function automatic res_t make_res(kind_t k, logic signed [31:0] v, err_t e, logic l);
    res_t r;
    r.kind       = k;
    r.value      = v;
    r.error_code = e;
    r.last       = l;
    return r;
  endfunction

  // Applies one command to the shadow stack and queues the results it must produce.
  function void execute_command(req_t r);
    logic signed [31:0] top_val;
    logic signed [31:0] next_val;
    case (cmd_t'(r.cmd))
      CMD_PUSH: begin
        if (stack_depth >= DEPTH) begin
          expected_q.push_back(make_res(KIND_ERROR, '0, ERR_OVERFLOW, 1'b1));
        end else begin
          stack_mem[stack_depth] = r.operand;
          stack_depth++;
          expected_q.push_back(make_res(KIND_ACK, '0, ERR_NONE, 1'b1));
        end
      end
      CMD_PALL: begin
        if (stack_depth == 0) begin
          expected_q.push_back(make_res(KIND_ACK, '0, ERR_NONE, 1'b1));
        end else begin
          for (int i = stack_depth - 1; i >= 0; i--)
            expected_q.push_back(make_res(KIND_VALUE, stack_mem[i], ERR_NONE, i == 0));
        end
      end
      CMD_PINT: begin
        if (stack_depth == 0)
          expected_q.push_back(make_res(KIND_ERROR, '0, ERR_PINT_EMPTY, 1'b1));
        else
          expected_q.push_back(make_res(KIND_VALUE, stack_mem[stack_depth - 1], ERR_NONE,
                                        1'b1));
      end
      CMD_POP: begin
        if (stack_depth == 0) begin
          expected_q.push_back(make_res(KIND_ERROR, '0, ERR_POP_EMPTY, 1'b1));
        end else begin
          stack_depth--;
          expected_q.push_back(make_res(KIND_ACK, '0, ERR_NONE, 1'b1));
        end
      end
      CMD_SWAP: begin
        if (stack_depth < 2) begin
          expected_q.push_back(make_res(KIND_ERROR, '0, ERR_SWAP_SHORT, 1'b1));
        end else begin
          top_val                    = stack_mem[stack_depth - 1];
          stack_mem[stack_depth - 1] = stack_mem[stack_depth - 2];
          stack_mem[stack_depth - 2] = top_val;
          expected_q.push_back(make_res(KIND_ACK, '0, ERR_NONE, 1'b1));
        end
      end
      CMD_ADD: begin
        if (stack_depth < 2) begin
          expected_q.push_back(make_res(KIND_ERROR, '0, ERR_ADD_SHORT, 1'b1));
        end else begin
          top_val                    = stack_mem[stack_depth - 1];
          next_val                   = stack_mem[stack_depth - 2];
          // 32-bit sum wraps on overflow
          stack_mem[stack_depth - 2] = top_val + next_val;
          stack_depth--;
          expected_q.push_back(make_res(KIND_ACK, '0, ERR_NONE, 1'b1));
        end
      end
      CMD_NOP: begin
        expected_q.push_back(make_res(KIND_ACK, '0, ERR_NONE, 1'b1));
      end
      default: begin
        expected_q.push_back(make_res(KIND_ERROR, '0, ERR_INVALID, 1'b1));
      end
    endcase
  endfunction

  task report_mismatch(string why, res_t got, res_t want);
    $display("%0t ns: %s: got kind=%0d value=%0d err=%0d last=%0d, want kind=%0d value=%0d err=%0d last=%0d",
             $time, why, got.kind, got.value, got.error_code, got.last,
             want.kind, want.value, want.error_code, want.last);
    fail_count++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      stack_depth = 0;
      expected_q.delete();
    end else begin
      // queue first so a same-edge result still finds its expectation
      if (start && !busy)
        execute_command(request);
      if (result_strobe) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no pending request", result, '0);
        end else begin
          want = expected_q.pop_front();
          if (result.kind !== want.kind || result.value !== want.value ||
              result.error_code !== want.error_code || result.last !== want.last)
            report_mismatch("result mismatch", result, want);
        end
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sme_pkg::*;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic result_strobe;
  res_t result;
  int   fail_count;
  int   outstanding;

  int depth_seen = 0;
  int idle_pct   = 0;
  int phase_idle [4] = '{0, 48, 0, 17};

  always #2 clk = ~clk;

  stack_machine_executor i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .result_strobe (result_strobe),
    .result        (result)
  );

  stack_machine_executor_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .result_strobe (result_strobe),
    .result        (result),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CMD_PUSH;
    if (r < 40) return CMD_PALL;
    if (r < 50) return CMD_PINT;
    if (r < 66) return CMD_POP;
    if (r < 76) return CMD_SWAP;
    if (r < 86) return CMD_ADD;
    if (r < 93) return CMD_NOP;
    return CMD_INVALID;
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic issue(cmd_t c, logic signed [31:0] v);
    req_t r;
    r.cmd     = c;
    r.operand = v;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    // rough occupancy, only used to steer the fill and drain bursts
    case (c)
      CMD_PUSH: if (depth_seen < DEPTH) depth_seen++;
      CMD_POP:  if (depth_seen > 0) depth_seen--;
      CMD_ADD:  if (depth_seen >= 2) depth_seen--;
      default: ;
    endcase
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty-stack errors and odd commands
    issue(CMD_PINT, '0);
    issue(CMD_POP, '1);
    issue(CMD_SWAP, '0);
    issue(CMD_ADD, '0);
    issue(CMD_PALL, '0);
    issue(CMD_NOP, 32'sh5A5A_A5A5);
    issue(CMD_INVALID, '1);
    issue(CMD_PUSH, 32'sh7FFF_FFFF);
    issue(CMD_SWAP, '0);
    issue(CMD_ADD, '0);
    issue(CMD_PINT, '0);
    issue(CMD_PUSH, 32'sh8000_0000);
    issue(CMD_PALL, '0);
    issue(CMD_SWAP, '1);
    issue(CMD_PALL, '0);
    issue(CMD_ADD, '0);
    issue(CMD_PINT, '0);
    issue(CMD_PUSH, '1);
    issue(CMD_PUSH, 32'sh0000_0001);
    issue(CMD_ADD, '0);
    issue(CMD_PALL, '0);
    issue(CMD_POP, '0);
    issue(CMD_POP, '0);
    issue(CMD_POP, '0);
    issue(CMD_INVALID, 32'sh1234_5678);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      if (ph == 1) begin
        // fill to the top, overflow twice, then read everything back
        while (depth_seen < DEPTH)
          issue(CMD_PUSH, pick_operand());
        issue(CMD_PUSH, pick_operand());
        issue(CMD_PUSH, pick_operand());
        issue(CMD_PALL, pick_operand());
        issue(CMD_PINT, pick_operand());
      end
      if (ph == 3) begin
        while (depth_seen > 0)
          issue(($urandom_range(0, 3) == 0) ? CMD_ADD : CMD_POP, pick_operand());
        issue(CMD_POP, pick_operand());
        issue(CMD_PINT, pick_operand());
        issue(CMD_PALL, pick_operand());
      end
      repeat (18)
        issue(pick_cmd(), pick_operand());
    end
    start <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("** stack_machine_executor: PASSED **");
    else
      $display("** stack_machine_executor: FAILED **");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** stack_machine_executor: FAILED **");
    $finish;
  end

endmodule
